// File: rtl/ptlh_pkg.sv
package ptlh_pkg;

    // Command codes carried in the action field
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SEND = 2'd1;
    localparam logic [1:0] ACT_RECV = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BUSY_TMO = 2'd1;
    localparam logic [1:0] ERR_ACK_TMO  = 2'd2;

    // Status pin positions
    localparam int unsigned BUSY_IN_BIT   = 6;
    localparam int unsigned STROBE_IN_BIT = 7;

    // Driven pin patterns
    localparam logic [4:0] PIN_NONE       = 5'h00;
    localparam logic [4:0] PIN_BUSY_OUT   = 5'h08;
    localparam logic [4:0] PIN_STROBE_OUT = 5'h10;

    // Tribble index of the last (two-bit) tribble
    localparam logic [1:0] TRIB_LAST = 2'd2;

    // Register map
    localparam logic REG_TIMEOUT_LIMIT = 1'b0;
    localparam logic [15:0] LIMIT_RESET = 16'd5000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX_DROP,
        PH_TX_ACK,
        PH_RX_BUSY,
        PH_RX_STROBE,
        PH_RX_RISE
    } phase_t;

    // One input transaction
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_byte;
        logic [7:0] status_in;
    } step_t;

    // One result transaction
    typedef struct packed {
        logic [4:0] data_out;
        logic [7:0] rx_byte;
        logic       byte_done;
        logic [1:0] error_code;
        logic       link_busy;
    } result_t;

endpackage

// File: rtl/parallel_tribble_link_host.sv
// Host side of a three-tribble parallel byte link. Each input transaction
// (tick, start send, start receive) is held in an input register, passes
// once through the handshake state machine and lands in a result register,
// giving exactly one result transaction per input transaction. When the
// output is not stalled, one transaction is taken every clock; the rate is
// set by the state update of the handshake machine. A stall on the output
// holds the result register and, once the input register is also full,
// raises in_stall. The send timeout counts failing status samples against
// the low TIMEOUT_WIDTH bits of timeout_limit (APB byte address 0, reset
// 5000); write it only while the link is idle.
module parallel_tribble_link_host #(
    parameter int TIMEOUT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  tx_byte,
    input  logic [7:0]  status_in,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  data_out,
    output logic [7:0]  rx_byte,
    output logic        byte_done,
    output logic [1:0]  error_code,
    output logic        link_busy
);
    import ptlh_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    step_t       s1_reg, s1_next;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;
    result_t     core_res;
    logic [15:0] timeout_limit;
    logic        in_take;
    logic        s1_move;

    ptlh_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .timeout_limit (timeout_limit)
    );

    ptlh_core #(
        .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (s1_move),
        .step          (s1_reg),
        .timeout_limit (timeout_limit),
        .result        (core_res)
    );

    // Handshake between the two register stages
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign s1_next        = in_take ? step_t'{action, tx_byte, status_in} : s1_reg;
    assign out_valid_next = s1_move ? 1'b1 : ((out_valid_reg && !out_stall) ? 1'b0
                                                                            : out_valid_reg);
    assign res_next       = s1_move ? core_res : res_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        res_reg <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = res_reg.data_out;
    assign rx_byte    = res_reg.rx_byte;
    assign byte_done  = res_reg.byte_done;
    assign error_code = res_reg.error_code;
    assign link_busy  = res_reg.link_busy;

    // A finished or aborted byte leaves the link idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_done || (error_code != ERR_NONE)) |-> !link_busy)
        else $error("link still busy after byte end");

    // Completion and abort never coincide
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(byte_done && (error_code != ERR_NONE)))
        else $error("byte both completed and aborted");

    // A received byte only shows on completion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rx_byte != 8'd0) |-> byte_done)
        else $error("received byte without completion");

    // A transaction moving out of the input register reaches the result register on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid)
        else $error("result transaction lost");

endmodule

// File: rtl/ptlh_cfg.sv
module ptlh_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] timeout_limit
);
    import ptlh_pkg::*;

    logic [15:0] limit_reg;
    logic [15:0] limit_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT_LIMIT);

    // Take the low half of the write data
    assign limit_next = wr_en ? pwdata[15:0] : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    // Read back the register, zero beyond the map
    assign prdata = (paddr[2] == REG_TIMEOUT_LIMIT) ? {16'd0, limit_reg} : 32'd0;

    assign timeout_limit = limit_reg;

endmodule

// File: rtl/ptlh_core.sv
module ptlh_core #(
    parameter int TIMEOUT_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  ptlh_pkg::step_t   step,
    input  logic [15:0]       timeout_limit,
    output ptlh_pkg::result_t result
);
    import ptlh_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [1:0]               idx_reg, idx_next;
    logic [7:0]               shift_reg, shift_next;
    logic [TIMEOUT_WIDTH:0]   wait_reg, wait_next;
    logic [4:0]               pin_reg, pin_next;

    logic [TIMEOUT_WIDTH-1:0] limit;
    logic [TIMEOUT_WIDTH:0]   wait_inc;
    logic                     timeout;
    logic                     start;
    logic                     busy_in;
    logic                     strobe_in;
    logic [1:0]               idx_inc;
    logic                     last;
    logic [2:0]               tx_trib;
    logic [2:0]               rx_trib;
    logic [7:0]               shift_merge;
    logic                     done;
    logic [1:0]               err;
    logic [7:0]               rxb;

    // Keep only the low TIMEOUT_WIDTH bits of the limit register
    always_comb
    begin
        limit = '0;
        for (int i = 0; i < TIMEOUT_WIDTH; i++)
        begin
            if (i < 16)
            begin
                limit[i] = timeout_limit[i];
            end
        end
    end

    assign wait_inc  = wait_reg + {{TIMEOUT_WIDTH{1'b0}}, 1'b1};
    assign timeout   = wait_inc > {1'b0, limit};
    assign start     = (step.action == ACT_SEND) || (step.action == ACT_RECV);
    assign busy_in   = step.status_in[BUSY_IN_BIT];
    assign strobe_in = step.status_in[STROBE_IN_BIT];
    assign idx_inc   = idx_reg + 2'd1;
    assign last      = (idx_reg == TRIB_LAST);

    // Select the tribble to send
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    tx_trib = shift_reg[2:0];
            2'd1:    tx_trib = shift_reg[5:3];
            2'd2:    tx_trib = {1'b0, shift_reg[7:6]};
            default: tx_trib = 3'd0;
        endcase
    end

    // Merge the received tribble into the byte, lowest first
    assign rx_trib = step.status_in[5:3];
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    shift_merge = shift_reg | {5'd0, rx_trib};
            2'd1:    shift_merge = shift_reg | {2'd0, rx_trib, 3'd0};
            2'd2:    shift_merge = shift_reg | {rx_trib[1:0], 6'd0};
            default: shift_merge = shift_reg;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (start)
        begin
            if (phase_reg == PH_IDLE)
            begin
                phase_next = (step.action == ACT_SEND) ? PH_TX_DROP : PH_RX_BUSY;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:      phase_next = PH_IDLE;
                PH_TX_DROP:
                begin
                    if (busy_in)
                    begin
                        if (timeout)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_TX_ACK;
                    end
                end
                PH_TX_ACK:
                begin
                    if (!busy_in)
                    begin
                        if (timeout)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        phase_next = last ? PH_IDLE : PH_TX_DROP;
                    end
                end
                PH_RX_BUSY:
                begin
                    if (busy_in)
                    begin
                        phase_next = PH_RX_STROBE;
                    end
                end
                PH_RX_STROBE:
                begin
                    if (!strobe_in)
                    begin
                        phase_next = PH_RX_RISE;
                    end
                end
                PH_RX_RISE:
                begin
                    if (strobe_in)
                    begin
                        phase_next = last ? PH_IDLE : PH_RX_BUSY;
                    end
                end
                default:      phase_next = PH_IDLE;
            endcase
        end
    end

    // Datapath and result flags
    always_comb
    begin
        idx_next   = idx_reg;
        shift_next = shift_reg;
        wait_next  = wait_reg;
        pin_next   = pin_reg;
        done       = 1'b0;
        err        = ERR_NONE;
        rxb        = 8'd0;
        if (start)
        begin
            if (phase_reg == PH_IDLE)
            begin
                idx_next  = 2'd0;
                wait_next = '0;
                if (step.action == ACT_SEND)
                begin
                    shift_next = step.tx_byte;
                    pin_next   = PIN_BUSY_OUT;
                end
                else
                begin
                    shift_next = 8'd0;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_TX_DROP:
                begin
                    if (busy_in)
                    begin
                        wait_next = wait_inc;
                        if (timeout)
                        begin
                            err = ERR_BUSY_TMO;
                        end
                    end
                    else
                    begin
                        pin_next  = PIN_STROBE_OUT | {2'd0, tx_trib};
                        wait_next = '0;
                    end
                end
                PH_TX_ACK:
                begin
                    if (!busy_in)
                    begin
                        wait_next = wait_inc;
                        if (timeout)
                        begin
                            err = ERR_ACK_TMO;
                        end
                    end
                    else
                    begin
                        pin_next  = PIN_BUSY_OUT;
                        wait_next = '0;
                        idx_next  = idx_inc;
                        done      = last;
                    end
                end
                PH_RX_BUSY:
                begin
                    if (busy_in)
                    begin
                        pin_next = PIN_NONE;
                    end
                end
                PH_RX_STROBE:
                begin
                    if (!strobe_in)
                    begin
                        shift_next = shift_merge;
                        pin_next   = PIN_BUSY_OUT;
                    end
                end
                PH_RX_RISE:
                begin
                    if (strobe_in)
                    begin
                        idx_next = idx_inc;
                        done     = last;
                        rxb      = last ? shift_reg : 8'd0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Advance the state once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= 2'd0;
            shift_reg <= 8'd0;
            wait_reg  <= '0;
            pin_reg   <= PIN_NONE;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            wait_reg  <= wait_next;
            pin_reg   <= pin_next;
        end
    end

    assign result.data_out   = pin_next;
    assign result.rx_byte    = rxb;
    assign result.byte_done  = done;
    assign result.error_code = err;
    assign result.link_busy  = (phase_next != PH_IDLE);

endmodule
